// File: rtl/dsph_pkg.sv
// shared types, codes and the half-step coil table for the dual stepper unit
package dsph_pkg;

   // request mode codes
   localparam logic [1:0] MODE_TICK = 2'd0;
   localparam logic [1:0] MODE_GOAL = 2'd1;
   localparam logic [1:0] MODE_HOME = 2'd2;

   // motor select codes
   localparam logic SEL_FRONT  = 1'b0;
   localparam logic SEL_BOTTOM = 1'b1;

   // steps in one coarse position unit (power of two)
   localparam int STEPS_PER_UNIT = 16;
   localparam logic signed [15:0] STEPS_DIV = 16'(STEPS_PER_UNIT);

   localparam logic signed [15:0] STEP_MAX = 16'sh7FFF;
   localparam logic signed [15:0] STEP_MIN = 16'sh8000;

   typedef struct packed {
      logic       en;
      logic       tick;
      logic       sensor;
      logic       load;
      logic       home;
      logic [7:0] goal;
   } motor_cmd_type;

   typedef struct packed {
      logic [3:0]         coils;
      logic signed [15:0] steps;
      logic               homing;
   } motor_view_type;

   // half-step coil pattern, bit3..bit0 drive coil inputs 1..4
   function automatic logic [3:0] coil_pattern(input logic [2:0] phase);
      logic [3:0] pat;
      case (phase)
         3'd0: pat = 4'hA;
         3'd1: pat = 4'h8;
         3'd2: pat = 4'h9;
         3'd3: pat = 4'h1;
         3'd4: pat = 4'h5;
         3'd5: pat = 4'h4;
         3'd6: pat = 4'h6;
         3'd7: pat = 4'h2;
         default: pat = 4'h0;
      endcase
      return pat;
   endfunction

endpackage

// File: rtl/dsph_req_if.sv
// request channel of the dual stepper unit
interface dsph_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] mode;
   logic       motor_sel;
   logic [7:0] goal_position;
   logic       limit_sensor;

   modport source (output valid, mode, motor_sel, goal_position, limit_sensor, input ready);
   modport sink   (input valid, mode, motor_sel, goal_position, limit_sensor, output ready);
endinterface

// File: rtl/dsph_rsp_if.sv
// response channel of the dual stepper unit
interface dsph_rsp_if;
   logic               valid;
   logic               ready;
   logic [3:0]         front_coils;
   logic [3:0]         bottom_coils;
   logic signed [15:0] front_step_count;
   logic signed [15:0] bottom_step_count;
   logic               front_homing_flag;
   logic               bottom_homing_flag;

   modport source (output valid, front_coils, bottom_coils, front_step_count,
                   bottom_step_count, front_homing_flag, bottom_homing_flag,
                   input ready);
   modport sink   (input valid, front_coils, bottom_coils, front_step_count,
                   bottom_step_count, front_homing_flag, bottom_homing_flag,
                   output ready);
endinterface

// File: rtl/dsph_motor.sv
// one stepper channel: state, goal tracking, homing and coil stepping
module dsph_motor (
   input  logic                     clock,
   input  logic                     reset,
   input  dsph_pkg::motor_cmd_type  cmd,
   output dsph_pkg::motor_view_type view
);
   import dsph_pkg::*;

   logic signed [15:0] steps_ff, steps_in;
   logic [7:0]         goal_ff, goal_in;
   logic               homing_ff, homing_in;
   logic [2:0]         phase_ff, phase_in;
   logic [3:0]         coil_ff, coil_in;

   logic signed [15:0] pos;
   logic signed [16:0] pos_x, goal_x;
   logic [2:0]         phase_open, phase_closed;
   logic               below, above;

   always_comb begin
      pos          = steps_ff / STEPS_DIV;   // truncates toward zero
      pos_x        = {pos[15], pos};
      goal_x       = {9'd0, goal_ff};
      below        = pos_x < goal_x;
      above        = pos_x > goal_x;
      phase_open   = phase_ff + 3'd1;
      phase_closed = phase_ff - 3'd1;

      steps_in  = steps_ff;
      goal_in   = goal_ff;
      homing_in = homing_ff;
      phase_in  = phase_ff;
      coil_in   = coil_ff;

      if (cmd.tick) begin
         if (homing_ff || above) begin
            if (cmd.sensor) begin
               steps_in  = '0;
               goal_in   = '0;
               homing_in = 1'b0;
            end else begin
               phase_in = phase_open;
               coil_in  = coil_pattern(phase_open);
               steps_in = (steps_ff == STEP_MIN) ? steps_ff : steps_ff - 16'sd1;
            end
         end else if (below) begin
            phase_in = phase_closed;
            coil_in  = coil_pattern(phase_closed);
            steps_in = (steps_ff == STEP_MAX) ? steps_ff : steps_ff + 16'sd1;
         end
      end
      if (cmd.load) begin
         goal_in = cmd.goal;
      end
      if (cmd.home) begin
         homing_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         steps_ff  <= '0;
         goal_ff   <= '0;
         homing_ff <= 1'b0;
         phase_ff  <= '0;
         coil_ff   <= '0;
      end else if (cmd.en) begin
         steps_ff  <= steps_in;
         goal_ff   <= goal_in;
         homing_ff <= homing_in;
         phase_ff  <= phase_in;
         coil_ff   <= coil_in;
      end
   end

   assign view.coils  = coil_in;
   assign view.steps  = steps_in;
   assign view.homing = homing_in;

endmodule

// File: rtl/dual_stepper_position_homing_unit.sv
// top level of the dual stepper position and homing unit
// path: a request is held in the request register, then its result in the response register
// throughput: one request per cycle, the request register and the response
// register each take a new item whenever the stage after them moves on
// reset: synchronous, clears both motors (steps, goals, homing, phase, coils)
// and empties the request and response registers
module dual_stepper_position_homing_unit (
   input logic        clock,
   input logic        reset,
   dsph_req_if.sink   req_chan,
   dsph_rsp_if.source rsp_chan
);
   import dsph_pkg::*;

   // request register
   logic       in_valid_ff, in_valid_in;
   logic [1:0] in_mode_ff;
   logic       in_sel_ff;
   logic [7:0] in_goal_ff;
   logic       in_sensor_ff;

   // response register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [3:0]         rsp_front_coils_ff, rsp_bottom_coils_ff;
   logic signed [15:0] rsp_front_steps_ff, rsp_bottom_steps_ff;
   logic               rsp_front_homing_ff, rsp_bottom_homing_ff;

   logic           req_take;   // request handshake completes
   logic           fire;       // held request is applied to the motors
   motor_cmd_type  front_cmd, bottom_cmd;
   motor_view_type front_view, bottom_view;

   // the held request moves on when the response slot is free or being drained
   assign fire     = in_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_take = req_chan.valid && req_chan.ready;
   assign req_chan.ready = !in_valid_ff || fire;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff;
      if (fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // decode the held request for each motor; ticks reach both, commands one
   always_comb begin
      front_cmd.en      = fire;
      front_cmd.tick    = (in_mode_ff == MODE_TICK);
      front_cmd.sensor  = in_sensor_ff;
      front_cmd.load    = (in_mode_ff == MODE_GOAL) && (in_sel_ff == SEL_FRONT);
      front_cmd.home    = (in_mode_ff == MODE_HOME) && (in_sel_ff == SEL_FRONT);
      front_cmd.goal    = in_goal_ff;

      bottom_cmd.en     = fire;
      bottom_cmd.tick   = (in_mode_ff == MODE_TICK);
      bottom_cmd.sensor = in_sensor_ff;
      bottom_cmd.load   = (in_mode_ff == MODE_GOAL) && (in_sel_ff == SEL_BOTTOM);
      bottom_cmd.home   = (in_mode_ff == MODE_HOME) && (in_sel_ff == SEL_BOTTOM);
      bottom_cmd.goal   = in_goal_ff;
   end

   dsph_motor u_front (
      .clock (clock),
      .reset (reset),
      .cmd   (front_cmd),
      .view  (front_view)
   );

   dsph_motor u_bottom (
      .clock (clock),
      .reset (reset),
      .cmd   (bottom_cmd),
      .view  (bottom_view)
   );

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_mode_ff   <= req_chan.mode;
         in_sel_ff    <= req_chan.motor_sel;
         in_goal_ff   <= req_chan.goal_position;
         in_sensor_ff <= req_chan.limit_sensor;
      end
      if (fire) begin
         rsp_front_coils_ff   <= front_view.coils;
         rsp_bottom_coils_ff  <= bottom_view.coils;
         rsp_front_steps_ff   <= front_view.steps;
         rsp_bottom_steps_ff  <= bottom_view.steps;
         rsp_front_homing_ff  <= front_view.homing;
         rsp_bottom_homing_ff <= bottom_view.homing;
      end
   end

   assign rsp_chan.valid              = rsp_valid_ff;
   assign rsp_chan.front_coils        = rsp_front_coils_ff;
   assign rsp_chan.bottom_coils       = rsp_bottom_coils_ff;
   assign rsp_chan.front_step_count   = rsp_front_steps_ff;
   assign rsp_chan.bottom_step_count  = rsp_bottom_steps_ff;
   assign rsp_chan.front_homing_flag  = rsp_front_homing_ff;
   assign rsp_chan.bottom_homing_flag = rsp_bottom_homing_ff;

   // request path only stalls while a request is held
   a_stall_held: assert property (@(posedge clock) disable iff (reset)
      !req_chan.ready |-> in_valid_ff)
      else $error("request path stalled with no request held");

   // every applied request shows up as a response
   a_fire_rsp: assert property (@(posedge clock) disable iff (reset)
      fire |=> rsp_chan.valid)
      else $error("applied request gave no response");

   // a tick with the sensor set leaves no motor homing
   a_sensor_ends_homing: assert property (@(posedge clock) disable iff (reset)
      fire && in_mode_ff == MODE_TICK && in_sensor_ff
      |=> !rsp_chan.front_homing_flag && !rsp_chan.bottom_homing_flag)
      else $error("homing still set after sensor tick");

endmodule

// File: tb/stepper_response_checker.sv
// response checker for the dual stepper unit: tracks both motors and compares every response
`timescale 1ns / 1ps

module stepper_response_checker (
   input  logic clock,
   input  logic reset,
   dsph_req_if  req_mon,
   dsph_rsp_if  rsp_mon,
   output int   fail_count,
   output int   pending_count
);
   import dsph_pkg::*;

   typedef struct packed {
      logic [3:0]         front_coils;
      logic [3:0]         bottom_coils;
      logic signed [15:0] front_steps;
      logic signed [15:0] bottom_steps;
      logic               front_homing;
      logic               bottom_homing;
   } motor_snapshot_type;

   // half-step coil patterns, phase 0 in the low nibble
   localparam logic [31:0] HALF_STEP_COILS = 32'h2645_198A;

   // tracked motor state, indexed by motor select code
   logic signed [15:0] steps_q  [2];
   logic [7:0]         goal_q   [2];
   logic               homing_q [2];
   logic [2:0]         phase_q  [2];
   logic [3:0]         coils_q  [2];

   motor_snapshot_type expected_snapshots [$];
   int mismatches = 0;

   function automatic void clear_motors();
      for (int m = 0; m < 2; m++) begin
         steps_q[m]  = '0;
         goal_q[m]   = '0;
         homing_q[m] = 1'b0;
         phase_q[m]  = '0;
         coils_q[m]  = '0;
      end
   endfunction

   function automatic void step_motor(int m, logic opening);
      if (opening) begin
         phase_q[m] = phase_q[m] + 3'd1;
         if (steps_q[m] != STEP_MIN) steps_q[m] = steps_q[m] - 16'sd1;
      end else begin
         phase_q[m] = phase_q[m] - 3'd1;
         if (steps_q[m] != STEP_MAX) steps_q[m] = steps_q[m] + 16'sd1;
      end
      coils_q[m] = HALF_STEP_COILS[{phase_q[m], 2'b00} +: 4];
   endfunction

   function automatic void tick_motor(int m, logic sensor);
      int coarse;
      int target;
      coarse = steps_q[m] / STEPS_PER_UNIT;
      target = goal_q[m];
      if (homing_q[m]) begin
         if (sensor) begin
            homing_q[m] = 1'b0;
            steps_q[m]  = '0;
            goal_q[m]   = '0;
         end else begin
            step_motor(m, 1'b1);
         end
      end else if (coarse < target) begin
         step_motor(m, 1'b0);
      end else if (coarse > target) begin
         if (sensor) begin
            steps_q[m] = '0;
            goal_q[m]  = '0;
         end else begin
            step_motor(m, 1'b1);
         end
      end
   endfunction

   function automatic motor_snapshot_type apply_request(logic [1:0] mode, logic sel,
                                                        logic [7:0] goal, logic sensor);
      motor_snapshot_type snap;
      case (mode)
         MODE_TICK: begin
            tick_motor(SEL_FRONT, sensor);
            tick_motor(SEL_BOTTOM, sensor);
         end
         MODE_GOAL: goal_q[sel] = goal;
         MODE_HOME: homing_q[sel] = 1'b1;
         default: ;
      endcase
      snap.front_coils   = coils_q[SEL_FRONT];
      snap.bottom_coils  = coils_q[SEL_BOTTOM];
      snap.front_steps   = steps_q[SEL_FRONT];
      snap.bottom_steps  = steps_q[SEL_BOTTOM];
      snap.front_homing  = homing_q[SEL_FRONT];
      snap.bottom_homing = homing_q[SEL_BOTTOM];
      return snap;
   endfunction

   function automatic void compare_field(string field, int want, int got);
      if (want != got) begin
         $error("%s expected %0d actual %0d", field, want, got);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin : watch
      motor_snapshot_type want;
      if (reset) begin
         clear_motors();
         expected_snapshots.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_snapshots.size() == 0) begin
               $error("response with no request outstanding");
               mismatches++;
            end else begin
               want = expected_snapshots.pop_front();
               compare_field("front_coils", want.front_coils, rsp_mon.front_coils);
               compare_field("bottom_coils", want.bottom_coils, rsp_mon.bottom_coils);
               compare_field("front_step_count", want.front_steps, rsp_mon.front_step_count);
               compare_field("bottom_step_count", want.bottom_steps,
                             rsp_mon.bottom_step_count);
               compare_field("front_homing_flag", want.front_homing,
                             rsp_mon.front_homing_flag);
               compare_field("bottom_homing_flag", want.bottom_homing,
                             rsp_mon.bottom_homing_flag);
            end
         end
         if (req_mon.valid && req_mon.ready)
            expected_snapshots.push_back(apply_request(req_mon.mode, req_mon.motor_sel,
                                                       req_mon.goal_position,
                                                       req_mon.limit_sensor));
      end
      pending_count <= expected_snapshots.size();
      fail_count    <= mismatches;
   end

endmodule

// File: tb/dual_stepper_position_homing_unit_tb.sv
// top of the dual stepper unit testbench: clock, reset, request stimulus and verdict
`timescale 1ns / 1ps

module dual_stepper_position_homing_unit_tb;
   import dsph_pkg::*;

   // mode code the block has no use for, it must leave both motors alone
   localparam logic [1:0] MODE_SPARE = 2'd3;

   localparam int SWEEP_REQUESTS   = 850;
   // a short run of open steps on both motors with the sensor held off
   localparam int HOMING_RUN_TICKS = 20;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   fail_count;
   int   pending_count;
   int   burst_left = 0;

   dsph_req_if req_bus ();
   dsph_rsp_if rsp_bus ();

   dual_stepper_position_homing_unit uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   stepper_response_checker response_check (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_bus),
      .rsp_mon       (rsp_bus),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   always #5 clock = ~clock;

   // overall limit, well beyond the slowest legal run
   initial begin : watchdog
      #10_000_000;
      $display("TB_ERROR");
      $finish;
   end

   // offer one request and hold it until taken; bursts end with a random gap
   task automatic send_request(input logic [1:0] mode, input logic sel,
                               input logic [7:0] goal, input logic sensor);
      int gap;
      req_bus.valid         <= 1'b1;
      req_bus.mode          <= mode;
      req_bus.motor_sel     <= sel;
      req_bus.goal_position <= goal;
      req_bus.limit_sensor  <= sensor;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(1, 24);
         // roughly a quarter of bursts run straight into the next one
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // stop offering and wait for every outstanding response
   task automatic settle_all();
      req_bus.valid <= 1'b0;
      // let the checker update first so the count already includes the last request taken
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   // response side: changes its stall style now and then, plus a periodic long
   // hold-off so that both pipeline registers fill up
   initial begin : response_acceptor
      int cycle_no;
      int style;
      int style_left;
      int hold_left;
      cycle_no   = 0;
      style      = 0;
      style_left = 0;
      hold_left  = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         cycle_no++;
         if (cycle_no % 5000 == 300) hold_left = 64;
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            if (style_left == 0) begin
               style      = $urandom_range(0, 2);
               style_left = $urandom_range(20, 120);
            end
            style_left--;
            case (style)
               0: rsp_bus.ready <= 1'b1;
               1: rsp_bus.ready <= ($urandom_range(0, 9) < 7);
               default: rsp_bus.ready <= (cycle_no % 3 == 0);
            endcase
         end
      end
   end

   initial begin : stimulus
      int         pick;
      logic [1:0] mode_pick;
      logic [7:0] goal_pick;
      req_bus.valid         = 1'b0;
      req_bus.mode          = MODE_TICK;
      req_bus.motor_sel     = SEL_FRONT;
      req_bus.goal_position = '0;
      req_bus.limit_sensor  = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed: spare mode with every other field high, changes nothing
      send_request(MODE_SPARE, SEL_BOTTOM, 8'hFF, 1'b1);
      // tick with both motors at goal
      send_request(MODE_TICK, SEL_FRONT, 8'h00, 1'b0);
      // front to one unit, bottom to the far end
      send_request(MODE_GOAL, SEL_FRONT, 8'd1, 1'b0);
      send_request(MODE_GOAL, SEL_BOTTOM, 8'hFF, 1'b0);
      // sixteen closing steps bring front to its goal; sensor ignored below goal
      for (int i = 0; i < 16; i++)
         send_request(MODE_TICK, SEL_FRONT, 8'h00, (i == 3));
      // front now above its goal: sensor clears it, bottom keeps closing
      send_request(MODE_GOAL, SEL_FRONT, 8'd0, 1'b0);
      send_request(MODE_TICK, SEL_FRONT, 8'h00, 1'b1);
      // homing the bottom: open steps, goal load leaves homing on, sensor ends it
      send_request(MODE_HOME, SEL_BOTTOM, 8'h00, 1'b0);
      send_request(MODE_TICK, SEL_BOTTOM, 8'h00, 1'b0);
      send_request(MODE_GOAL, SEL_BOTTOM, 8'd3, 1'b0);
      send_request(MODE_TICK, SEL_FRONT, 8'h00, 1'b0);
      send_request(MODE_TICK, SEL_FRONT, 8'h00, 1'b1);
      settle_all();

      // random sweep: mostly ticks toward small goals, some homing and noise
      repeat (SWEEP_REQUESTS) begin
         pick = $urandom_range(0, 99);
         if (pick < 62)      mode_pick = MODE_TICK;
         else if (pick < 82) mode_pick = MODE_GOAL;
         else if (pick < 94) mode_pick = MODE_HOME;
         else                mode_pick = MODE_SPARE;
         goal_pick = ($urandom_range(0, 19) == 0) ? 8'($urandom_range(0, 255))
                                                  : 8'($urandom_range(0, 6));
         send_request(mode_pick, 1'($urandom_range(0, 1)), goal_pick,
                      ($urandom_range(0, 7) == 0));
      end
      settle_all();

      // homing run on both motors without the sensor: counters keep falling
      // and the coils keep turning until the sensor tick ends it
      send_request(MODE_HOME, SEL_FRONT, 8'($urandom_range(0, 255)), 1'b1);
      send_request(MODE_HOME, SEL_BOTTOM, 8'($urandom_range(0, 255)), 1'b1);
      repeat (HOMING_RUN_TICKS)
         send_request(MODE_TICK, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)), 1'b0);
      send_request(MODE_TICK, SEL_FRONT, 8'h00, 1'b1);
      settle_all();

      // keep the clock running to catch any stray response
      repeat (8) @(posedge clock);
      if (fail_count == 0 && pending_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
